// ===== rtl/ring_coherence_directory_assert.svh =====
`ifndef RING_COHERENCE_DIRECTORY_ASSERT_SVH
`define RING_COHERENCE_DIRECTORY_ASSERT_SVH

// same-cycle implication
`define RCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcd_pkg.sv =====
package rcd_pkg;

  localparam int TILE_ID_W  = 5;
  localparam int TILE_CNT_W = 6;
  localparam int HOP_W      = 4;
  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 11;
  localparam int ACT_W      = 3;
  localparam int LAT_W      = 9;
  localparam int EXTRA_W    = 2;

  // remainder unit: address bits consumed per cycle
  localparam int MOD_BITS   = 4;
  localparam int MOD_STEPS  = ADDR_W / MOD_BITS;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam logic [SIZE_W-1:0] MEM_REQ_BYTES = 11'd8;

  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd1;
  localparam logic [ACT_W-1:0] ACT_HIT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INVAL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FULL  = 3'd4;

  localparam logic [EXTRA_W-1:0] EXTRA_NONE   = 2'd0;
  localparam logic [EXTRA_W-1:0] EXTRA_SHARED = 2'd1;
  localparam logic [EXTRA_W-1:0] EXTRA_ABSENT = 2'd2;

  localparam logic [1:0] REG_TILE_COUNT = 2'd0;
  localparam logic [1:0] REG_DIR_ENABLE = 2'd1;
  localparam logic [1:0] REG_HOP_LAT    = 2'd2;

  localparam logic [TILE_CNT_W-1:0] TILE_COUNT_RST = 6'd8;
  localparam logic [HOP_W-1:0]      HOP_LAT_RST    = 4'd2;

  typedef struct packed {
    logic [7:0]        src_tile;
    logic [7:0]        dst_tile;
    logic [ADDR_W-1:0] mem_address;
    logic [SIZE_W-1:0] message_bytes;
  } rcd_req_t;

  typedef struct packed {
    logic                 accepted;
    logic [TILE_ID_W-1:0] routed_dest;
    logic [TILE_ID_W-1:0] home_id;
    logic [ACT_W-1:0]     action;
    logic [LAT_W-1:0]     latency;
  } rcd_rsp_t;

  typedef struct packed {
    logic [TILE_CNT_W-1:0] tile_count;
    logic                  directory_enable;
    logic [HOP_W-1:0]      hop_latency;
  } rcd_cfg_t;

endpackage

// ===== rtl/ring_coherence_directory.sv =====
// Ring message front end with a distributed line directory. One message is in
// flight at a time. A rejected message or one without a directory action goes
// from acceptance straight to the result state. A directory request first has
// its home tile found by a remainder unit taking 4 address bits a cycle, then
// the home tile's lines, up to its fill count, are read from the directory RAM
// one per cycle until a tag matches, followed by a write-back state and a
// state that loads the result once the output register is free. A finished
// result waits in the output register while the next message is taken. No
// clearing pass after reset: per-tile fill counts mark which lines are valid.
`include "ring_coherence_directory_assert.svh"

module ring_coherence_directory
  import rcd_pkg::*;
#(
  parameter int MAX_TILES        = 32,
  parameter int ENTRIES_PER_TILE = 64,
  parameter int LINE_BYTES       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  rcd_req_t    req_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rcd_rsp_t    rsp_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TILE_W  = $clog2(MAX_TILES);
  localparam int ENT_W   = (ENTRIES_PER_TILE > 1) ? $clog2(ENTRIES_PER_TILE) : 1;
  localparam int CNT_W   = $clog2(ENTRIES_PER_TILE + 1);
  localparam int DEPTH   = MAX_TILES * ENTRIES_PER_TILE;
  localparam int MEM_AW  = $clog2(DEPTH);
  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int TAG_W   = ADDR_W - OFF_W;
  localparam int ENTRY_W = TAG_W + TILE_ID_W + MAX_TILES + 1;
  localparam int OWN_LSB = MAX_TILES + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MOD    = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  rcd_cfg_t cfg;

  logic [2:0] state;
  logic [2:0] state_next;

  logic                  req_fire;
  logic                  req_rej;
  logic                  req_dir;
  logic [TILE_CNT_W-1:0] n_cur;
  logic                  mod_start;
  logic                  mod_done;
  logic [TILE_ID_W-1:0]  mod_rem;

  // per-message context
  logic [TILE_ID_W-1:0]  src_r;
  logic [TILE_ID_W-1:0]  routed_r;
  logic [TILE_ID_W-1:0]  home_r;
  logic [TAG_W-1:0]      tag_r;
  logic [TILE_CNT_W-1:0] n_r;
  logic                  wr_r;
  logic                  rej_r;
  logic                  dir_r;
  logic [ACT_W-1:0]      action_r;
  logic [EXTRA_W-1:0]    extra_r;

  // scan and captured line
  logic [CNT_W-1:0]      scan_idx;
  logic [ENT_W-1:0]      cmp_idx;
  logic                  cmp_valid;
  logic                  hit_r;
  logic [ENT_W-1:0]      hit_idx;
  logic [TILE_ID_W-1:0]  hit_owner;
  logic [MAX_TILES-1:0]  hit_sharers;
  logic                  hit_mod;

  logic [CNT_W-1:0]      used_cnt [MAX_TILES];
  logic [TILE_W-1:0]     home_idx;
  logic [CNT_W-1:0]      used_cur;

  logic                  mem_we;
  logic [MEM_AW-1:0]     row_base;
  logic [MEM_AW-1:0]     mem_waddr;
  logic [MEM_AW-1:0]     mem_raddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic [ENTRY_W-1:0]    rd_data;
  logic [TAG_W-1:0]      rd_tag;
  logic [TILE_ID_W-1:0]  rd_owner;
  logic [MAX_TILES-1:0]  rd_sharers;
  logic                  rd_mod;

  logic                  tag_hit;
  logic                  scan_end;
  logic [MAX_TILES-1:0]  src_bit;
  logic                  do_inval;
  logic                  do_alloc;
  logic [ENT_W-1:0]      wr_idx;

  logic                  rsp_load;
  logic [TILE_ID_W-1:0]  diff;
  logic [TILE_CNT_W-1:0] wrap;
  logic [TILE_ID_W-1:0]  hops;
  logic [LAT_W-1:0]      total;

  rcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcd_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (req_data.mem_address),
    .divisor   (n_cur),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  rcd_dir_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH),
    .AW     (MEM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign n_cur = (cfg.tile_count > TILE_CNT_W'(MAX_TILES)) ?
                 TILE_CNT_W'(MAX_TILES) : cfg.tile_count;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign req_rej   = ({2'b00, n_cur} <= req_data.src_tile) ||
                     ({2'b00, n_cur} <= req_data.dst_tile);
  assign req_dir   = cfg.directory_enable && (req_data.message_bytes >= MEM_REQ_BYTES);
  assign mod_start = req_fire && !req_rej && req_dir;

  assign home_idx = home_r[TILE_W-1:0];
  assign used_cur = used_cnt[home_idx];
  assign row_base = MEM_AW'(home_idx) * MEM_AW'(ENTRIES_PER_TILE);

  assign rd_mod     = rd_data[0];
  assign rd_sharers = rd_data[MAX_TILES:1];
  assign rd_owner   = rd_data[OWN_LSB +: TILE_ID_W];
  assign rd_tag     = rd_data[ENTRY_W-1 -: TAG_W];

  assign tag_hit  = cmp_valid && (rd_tag == tag_r);
  assign scan_end = (scan_idx == used_cur);

  assign src_bit  = {{(MAX_TILES-1){1'b0}}, 1'b1} << src_r;
  assign do_inval = hit_r && (hit_owner != src_r) && hit_mod;
  assign do_alloc = !hit_r && (used_cur < CNT_W'(ENTRIES_PER_TILE));
  assign wr_idx   = hit_r ? hit_idx : used_cur[ENT_W-1:0];

  assign mem_raddr = row_base + MEM_AW'(scan_idx[ENT_W-1:0]);
  assign mem_waddr = row_base + MEM_AW'(wr_idx);
  assign mem_we    = (state == ST_UPD) && (hit_r || do_alloc);
  assign mem_wdata = {tag_r, src_r,
                      do_inval ? (hit_sharers & ~src_bit) : src_bit,
                      do_inval ? 1'b1 : wr_r};

  assign rsp_load = (state == ST_FIN) && (!rsp_valid || rsp_ready);

  // ring distance and latency
  assign diff  = (src_r >= routed_r) ? (src_r - routed_r) : (routed_r - src_r);
  assign wrap  = n_r - {1'b0, diff};
  assign hops  = ({1'b0, diff} < wrap) ? diff : wrap[TILE_ID_W-1:0];
  assign total = LAT_W'(hops) * LAT_W'(cfg.hop_latency) +
                 (dir_r ? (LAT_W'(hops) + LAT_W'(extra_r)) : LAT_W'(0));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_fire) state_next = (req_rej || !req_dir) ? ST_FIN : ST_MOD;
      ST_MOD:    if (mod_done) state_next = ST_SEARCH;
      ST_SEARCH: if (tag_hit || scan_end) state_next = ST_UPD;
      ST_UPD:    state_next = ST_FIN;
      ST_FIN:    if (rsp_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      cmp_valid <= 1'b0;
      for (int t = 0; t < MAX_TILES; t++) begin
        used_cnt[t] <= '0;
      end
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_SEARCH && !tag_hit && !scan_end) begin
        cmp_valid <= 1'b1;
      end else begin
        cmp_valid <= 1'b0;
      end
      if (state == ST_UPD && do_alloc) begin
        used_cnt[home_idx] <= used_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          src_r    <= req_data.src_tile[TILE_ID_W-1:0];
          routed_r <= req_data.dst_tile[TILE_ID_W-1:0];
          tag_r    <= req_data.mem_address[ADDR_W-1:OFF_W];
          wr_r     <= req_data.message_bytes > MEM_REQ_BYTES;
          n_r      <= n_cur;
          rej_r    <= req_rej;
          dir_r    <= !req_rej && req_dir;
          home_r   <= '0;
          action_r <= ACT_NONE;
          extra_r  <= EXTRA_NONE;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          home_r   <= mod_rem;
          scan_idx <= '0;
        end
      end
      ST_SEARCH: begin
        if (tag_hit) begin
          hit_r       <= 1'b1;
          hit_idx     <= cmp_idx;
          hit_owner   <= rd_owner;
          hit_sharers <= rd_sharers;
          hit_mod     <= rd_mod;
        end else if (scan_end) begin
          hit_r <= 1'b0;
        end else begin
          cmp_idx  <= scan_idx[ENT_W-1:0];
          scan_idx <= scan_idx + 1'b1;
        end
      end
      ST_UPD: begin
        if (do_inval) begin
          action_r <= ACT_INVAL;
          routed_r <= home_r;
          extra_r  <= EXTRA_SHARED;
        end else if (hit_r) begin
          action_r <= ACT_HIT;
          extra_r  <= EXTRA_NONE;
        end else if (do_alloc) begin
          action_r <= ACT_ALLOC;
          extra_r  <= EXTRA_NONE;
        end else begin
          action_r <= ACT_FULL;
          extra_r  <= EXTRA_ABSENT;
        end
      end
      default: ;
    endcase
    if (rsp_load) begin
      rsp_data.accepted    <= !rej_r;
      rsp_data.routed_dest <= rej_r ? '0 : routed_r;
      rsp_data.home_id     <= rej_r ? '0 : home_r;
      rsp_data.action      <= rej_r ? ACT_NONE : action_r;
      rsp_data.latency     <= rej_r ? '0 : total;
    end
  end

  `RCD_ASSERT_IMPL(a_scan_bound, clk, rst, state == ST_SEARCH, scan_idx <= used_cur, "scan beyond fill count")
  `RCD_ASSERT_IMPL(a_wr_only_upd, clk, rst, mem_we, state == ST_UPD, "directory write outside update")
  `RCD_ASSERT_NEXT(a_accept_busy, clk, rst, req_fire, state != ST_IDLE, "idle right after accept")
  `RCD_ASSERT_IMPL(a_home_range, clk, rst, state == ST_FIN && dir_r, {1'b0, home_r} < n_r, "home tile out of range")

endmodule

// ===== rtl/rcd_cfg_regs.sv =====
module rcd_cfg_regs
  import rcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rcd_cfg_t    cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_count       <= TILE_COUNT_RST;
      cfg.directory_enable <= 1'b1;
      cfg.hop_latency      <= HOP_LAT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TILE_COUNT: cfg.tile_count       <= pwdata[TILE_CNT_W-1:0];
        REG_DIR_ENABLE: cfg.directory_enable <= pwdata[0];
        REG_HOP_LAT:    cfg.hop_latency      <= pwdata[HOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TILE_COUNT: prdata = {{(32-TILE_CNT_W){1'b0}}, cfg.tile_count};
      REG_DIR_ENABLE: prdata = {31'd0, cfg.directory_enable};
      REG_HOP_LAT:    prdata = {{(32-HOP_W){1'b0}}, cfg.hop_latency};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/rcd_mod_unit.sv =====
module rcd_mod_unit
  import rcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ADDR_W-1:0]     dividend,
  input  logic [TILE_CNT_W-1:0] divisor,
  output logic                  done,
  output logic [TILE_ID_W-1:0]  remainder
);

  logic                  busy;
  logic [MOD_CNT_W-1:0]  cnt;
  logic [TILE_CNT_W-1:0] rem;
  logic [TILE_CNT_W-1:0] rem_next;
  logic [TILE_CNT_W-1:0] div_r;
  logic [ADDR_W-1:0]     sh;

  // restoring remainder, MOD_BITS digits per cycle, MSB first
  always_comb begin
    rem_next = rem;
    for (int k = 0; k < MOD_BITS; k++) begin
      rem_next = {rem_next[TILE_CNT_W-2:0], sh[ADDR_W-1-k]};
      if (rem_next >= div_r) begin
        rem_next = rem_next - div_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      sh    <= dividend;
      div_r <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      sh  <= sh << MOD_BITS;
    end
  end

  assign remainder = rem[TILE_ID_W-1:0];

endmodule

// ===== rtl/rcd_dir_ram.sv =====
module rcd_dir_ram #(
  parameter int DATA_W = 96,
  parameter int DEPTH  = 2048,
  parameter int AW     = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import rcd_pkg::*;

  localparam int TILES_MAX   = 32;
  localparam int DIR_ENTRIES = 64;
  localparam int LINE_SIZE   = 64;
  localparam int ADDR_POOL   = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  rcd_req_t    req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rcd_rsp_t    rsp_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ring_coherence_directory #(
    .MAX_TILES(TILES_MAX),
    .ENTRIES_PER_TILE(DIR_ENTRIES),
    .LINE_BYTES(LINE_SIZE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the line directory and the register file
  logic [63:0]   dir_tag     [TILES_MAX][DIR_ENTRIES];
  logic [4:0]    dir_owner   [TILES_MAX][DIR_ENTRIES];
  logic [31:0]   dir_sharers [TILES_MAX][DIR_ENTRIES];
  bit            dir_dirty   [TILES_MAX][DIR_ENTRIES];
  int unsigned   dir_fill    [TILES_MAX];
  logic [5:0]    cfg_tiles = TILE_COUNT_RST;
  logic          cfg_dir_en = 1'b1;
  logic [3:0]    cfg_hop = HOP_LAT_RST;

  rcd_req_t      outbound_msgs[$];
  rcd_rsp_t      pending_replies[$];
  logic [63:0]   addr_pool[ADDR_POOL];
  bit            steady_flow = 1'b0;
  bit            req_fire = 1'b0;
  bit            rsp_fire = 1'b0;
  int unsigned   error_count = 0;

  initial begin
    for (int t = 0; t < TILES_MAX; t++) dir_fill[t] = 0;
  end

  function automatic rcd_rsp_t predict_reply(rcd_req_t m);
    rcd_rsp_t    r;
    int unsigned n, src, dst, home, extra, hops, dir_lat, total, i;
    logic [63:0] line;
    logic [31:0] sharer_bit;
    int          slot;
    r = '0;
    n = (cfg_tiles > TILES_MAX) ? TILES_MAX : cfg_tiles;
    src = m.src_tile;
    dst = m.dst_tile;
    if (src >= n || dst >= n) return r;
    r.accepted = 1'b1;
    r.routed_dest = dst[4:0];
    r.action = ACT_NONE;
    dir_lat = 0;
    extra = 0;
    if (cfg_dir_en && m.message_bytes >= MEM_REQ_BYTES) begin
      line = m.mem_address & ~64'(LINE_SIZE - 1);
      sharer_bit = 32'd1 << src;
      home = int'(m.mem_address % 64'(n));
      r.home_id = home[4:0];
      slot = -1;
      for (i = 0; i < dir_fill[home]; i++)
        if (slot < 0 && dir_tag[home][i] == line) slot = i;
      if (slot >= 0 && dir_owner[home][slot] != src && dir_dirty[home][slot]) begin
        dir_sharers[home][slot] &= ~sharer_bit;
        dir_owner[home][slot] = src[4:0];
        r.routed_dest = home[4:0];
        r.action = ACT_INVAL;
      end else if (slot >= 0) begin
        dir_owner[home][slot] = src[4:0];
        dir_sharers[home][slot] = sharer_bit;
        dir_dirty[home][slot] = m.message_bytes > MEM_REQ_BYTES;
        r.action = ACT_HIT;
      end else if (dir_fill[home] < DIR_ENTRIES) begin
        slot = dir_fill[home];
        dir_tag[home][slot] = line;
        dir_owner[home][slot] = src[4:0];
        dir_sharers[home][slot] = sharer_bit;
        dir_dirty[home][slot] = m.message_bytes > MEM_REQ_BYTES;
        dir_fill[home] = slot + 1;
        r.action = ACT_ALLOC;
      end else begin
        r.action = ACT_FULL;
      end
      if (slot < 0) extra = 2;
      else if (dir_dirty[home][slot] && dir_owner[home][slot] != src) extra = 3;
      else if (dir_sharers[home][slot] != sharer_bit) extra = 1;
      else extra = 0;
    end
    hops = (src > r.routed_dest) ? src - r.routed_dest : r.routed_dest - src;
    if (n - hops < hops) hops = n - hops;
    if (r.action != ACT_NONE) dir_lat = hops + extra;
    total = hops * cfg_hop + dir_lat;
    r.latency = total[8:0];
    return r;
  endfunction

  function automatic rcd_req_t random_msg();
    rcd_req_t    m;
    int unsigned lim, pick;
    lim = (cfg_tiles == 0) ? 1 : ((cfg_tiles > TILES_MAX) ? TILES_MAX : cfg_tiles);
    pick = $urandom_range(0, 15);
    m.src_tile = (pick == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
    pick = $urandom_range(0, 15);
    m.dst_tile = (pick == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
    pick = $urandom_range(0, 9);
    m.mem_address = (pick < 7) ? addr_pool[$urandom_range(0, ADDR_POOL - 1)]
                               : {$urandom, $urandom};
    pick = $urandom_range(0, 11);
    case (pick)
      0:       m.message_bytes = 11'($urandom_range(0, 7));
      1, 2, 3: m.message_bytes = MEM_REQ_BYTES;
      4:       m.message_bytes = 11'($urandom);
      default: m.message_bytes = 11'($urandom_range(9, 1024));
    endcase
    return m;
  endfunction

  // beat detection and result checking
  always @(posedge clk) begin
    rcd_rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
      rsp_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && req_ready;
      rsp_fire <= rsp_valid && rsp_ready;
      if (rsp_valid && rsp_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result %h", $time, rsp_data);
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_data.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0d actual %0d", $time,
                     want.accepted, rsp_data.accepted);
            error_count++;
          end
          if (rsp_data.routed_dest !== want.routed_dest) begin
            $display("%0t: routed_dest expected %0d actual %0d", $time,
                     want.routed_dest, rsp_data.routed_dest);
            error_count++;
          end
          if (rsp_data.home_id !== want.home_id) begin
            $display("%0t: home_id expected %0d actual %0d", $time,
                     want.home_id, rsp_data.home_id);
            error_count++;
          end
          if (rsp_data.action !== want.action) begin
            $display("%0t: action expected %0d actual %0d", $time,
                     want.action, rsp_data.action);
            error_count++;
          end
          if (rsp_data.latency !== want.latency) begin
            $display("%0t: latency expected %0d actual %0d", $time,
                     want.latency, rsp_data.latency);
            error_count++;
          end
        end
      end
      if (req_valid && req_ready) pending_replies = {pending_replies, predict_reply(req_data)};
    end
  end

  // message driver
  always @(negedge clk) begin
    static int unsigned gap_left = 0;
    if (!rst) begin
      if (req_fire) gap_left = steady_flow ? 0 : $urandom_range(0, 13);
      if (!(req_valid && !req_fire)) begin
        if (gap_left > 0) begin
          req_valid <= 1'b0;
          gap_left--;
        end else if (outbound_msgs.size() > 0) begin
          req_data <= outbound_msgs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    static int unsigned stall_left = 0;
    static int unsigned beats = 0;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_fire) begin
        beats++;
        if (beats == 150) stall_left = 600;
        else stall_left = steady_flow ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TILE_COUNT: cfg_tiles = value[5:0];
      REG_DIR_ENABLE: cfg_dir_en = value[0];
      REG_HOP_LAT:    cfg_hop = value[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (outbound_msgs.size() != 0 || req_valid || pending_replies.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reconfigure(input int unsigned tiles, input int unsigned dir_en,
                             input int unsigned hop);
    wait_idle();
    write_reg(REG_TILE_COUNT, tiles);
    write_reg(REG_DIR_ENABLE, dir_en);
    write_reg(REG_HOP_LAT, hop);
    steady_flow = ($urandom_range(0, 3) == 0);
  endtask

  task automatic push_msg(input int unsigned src, input int unsigned dst,
                          input logic [63:0] addr, input int unsigned size);
    rcd_req_t m;
    m.src_tile = src[7:0];
    m.dst_tile = dst[7:0];
    m.mem_address = addr;
    m.message_bytes = size[10:0];
    outbound_msgs = {outbound_msgs, m};
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) outbound_msgs = {outbound_msgs, random_msg()};
  endtask

  initial begin
    for (int k = 0; k < ADDR_POOL; k++) addr_pool[k] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: allocate, hit, upgrade to modified, steal, rejects
    push_msg(0, 7, 64'h0, 8);
    push_msg(0, 7, 64'h0, 8);
    push_msg(3, 1, 64'h0, 16);
    push_msg(5, 2, 64'h0, 8);
    push_msg(5, 5, 64'h0, 9);
    push_msg(2, 6, 64'h0, 8);
    push_msg(1, 4, 64'h40, 0);
    push_msg(1, 4, 64'h40, 7);
    push_msg(8, 0, 64'h40, 8);
    push_msg(0, 8, 64'h40, 8);
    push_msg(255, 255, 64'hFFFF_FFFF_FFFF_FFFF, 8);
    push_msg(7, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1024);
    push_msg(6, 3, 64'hFFFF_FFFF_FFFF_FFC0, 2047);
    push_msg(4, 4, 64'hAAAA_5555_AAAA_5555, 64);
    push_msg(7, 7, 64'hFFFF_FFFF_FFFF_FFFF, 8);

    // single tile: every line homes to tile 0, filling its directory until it is full
    reconfigure(1, 1, 1);
    for (int k = 0; k < 70; k++) push_msg(0, 0, 64'(k) << 6, 8 + (k % 3));
    push_msg(0, 0, 64'h0, 8);
    push_msg(0, 0, 64'(69) << 6, 16);
    push_random(10);

    reconfigure(32, 1, 15);
    push_random(250);
    reconfigure(5, 1, 7);
    push_random(200);
    reconfigure(8, 0, 3);
    push_random(100);
    reconfigure(0, 1, 2);
    push_random(20);
    reconfigure(63, 1, 0);
    push_random(150);
    reconfigure(3, 1, 1);
    push_random(200);
    reconfigure(2, 1, 4);
    push_random(80);

    wait_idle();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
